// ===== design/sbvs_pkg.sv =====
// Shared types and constants for the sparse bitmap value store.
// No dependencies.
package sbvs_pkg;
  localparam int unsigned NumSlots = 256;
  localparam int unsigned KeyW     = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned DataW    = 64;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Command broadcast from the controller to every slot cell.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'b001,
    CMD_WRITE = 3'b010,
    CMD_SHIFT = 3'b100
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [KeyW-1:0]   idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic              mode;
    logic [KeyW-1:0]   key_byte;
    logic [DataW-1:0]  data_value;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  read_value;
    logic              was_present;
    logic [CountW-1:0] key_count;
  } rsp_t;
endpackage

// ===== design/sbvs_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing.
interface sbvs_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sbvs_cell.sv =====
// One value slot of the chain: holds a value and passes it to the next cell.
// Depends on sbvs_pkg.
module sbvs_cell import sbvs_pkg::*; #(
  parameter int unsigned VW = 64,
  parameter int unsigned Index = 0
) (
  input  logic           clk_i,
  input  cell_ctrl_t     ctrl_i,
  input  logic [VW-1:0]  wdata_i,
  input  logic [VW-1:0]  prev_i,
  output logic [VW-1:0]  value_o
);
  logic [VW-1:0] value_q;

  // Shift takes the lower neighbor's value for cells above the insert point;
  // the cell at the insert point takes the new value.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CMD_WRITE: if (ctrl_i.idx == KeyW'(Index)) value_q <= wdata_i;
      CMD_SHIFT: begin
        if (KeyW'(Index) > ctrl_i.idx) value_q <= prev_i;
        else if (KeyW'(Index) == ctrl_i.idx) value_q <= wdata_i;
      end
      default: ;
    endcase
  end
  assign value_o = value_q;
endmodule

// ===== design/sparse_bitmap_value_store_top.sv =====
// Top level: controller, presence bitmap and the chain of slot cells.
// Depends on sbvs_pkg, sbvs_if, sbvs_cell.
//
//  channel | dir | payload
//  in_ch   | in  | mode, key_byte, data_value
//  out_ch  | out | read_value, was_present, key_count
//
// Rank counting walks the bitmap one slot a cycle from slot 0 up to the key;
// then the result is registered in S_EXEC and offered to out_ch in S_OUT.
// Insert shifts the whole chain at once in S_EXEC. The dense switch adds a walk of
// all 256 slots backwards, one per cycle. Reset clears bitmap, count and direct mode;
// output holds until taken and no new item is taken meanwhile.
module sparse_bitmap_value_store_top import sbvs_pkg::*; #(
  parameter int unsigned DENSE_SWITCH = 128,
  parameter int unsigned VALUE_WIDTH  = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  sbvs_if.sink   in_ch,
  sbvs_if.source out_ch
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RANK  = 5'b00010,
    S_DENSE = 5'b00100,
    S_EXEC  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [NumSlots-1:0] bits_q;
  logic direct_q;
  logic [CountW-1:0] count_q;
  logic mode_q;
  logic [KeyW-1:0] key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CountW-1:0] scan_q;   // scan position
  logic [CountW-1:0] rank_q;   // present keys below scan
  logic pres_q;
  logic [DataW-1:0] rd_q;
  cell_ctrl_t ctrl;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] slot_v [NumSlots];
  logic [VALUE_WIDTH-1:0] dense_v [NumSlots];
  logic go_dense;

  genvar g;
  for (g = 0; g < NumSlots; g++) begin : g_cell
    sbvs_cell #(.VW(VALUE_WIDTH), .Index(g)) u_cell (
      .clk_i, .ctrl_i(ctrl), .wdata_i(wdata),
      .prev_i(g == 0 ? slot_v[0] : slot_v[(g == 0) ? 0 : g-1]),
      .value_o(slot_v[g])
    );
  end
  assign dense_v = slot_v;

  // Dense walk: scan key k from 255 down; rank_q holds count of bits <= k.
  logic [KeyW-1:0] sk;
  assign sk = scan_q[KeyW-1:0];

  assign go_dense = (mode_q == MODE_PUT) && !pres_q && !direct_q
                    && (count_q >= CountW'(DENSE_SWITCH));

  always_comb begin
    ctrl.cmd = CMD_NONE;
    ctrl.idx = '0;
    wdata = val_q;
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_ch.valid) state_d = S_RANK;
      S_RANK: if (scan_q == CountW'(key_q)) begin
        if (go_dense) state_d = S_DENSE;
        else state_d = S_EXEC;
      end
      S_DENSE: begin
        if (bits_q[sk]) begin
          ctrl.cmd = CMD_WRITE;
          ctrl.idx = sk;
          wdata = dense_v[rank_q[KeyW-1:0] - KeyW'(1)];
        end
        if (sk == '0) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (mode_q == MODE_PUT) begin
          ctrl.idx = direct_q ? key_q : rank_q[KeyW-1:0];
          ctrl.cmd = (pres_q || direct_q) ? CMD_WRITE : CMD_SHIFT;
        end
        state_d = S_OUT;
      end
      S_OUT: if (out_ch.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bits_q <= '0;
      direct_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_DENSE: if (sk == '0) direct_q <= 1'b1;
        S_EXEC: if (mode_q == MODE_PUT && !pres_q) begin
          bits_q[key_q] <= 1'b1;
          count_q <= count_q + CountW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        mode_q <= in_ch.payload.mode;
        key_q <= in_ch.payload.key_byte;
        val_q <= in_ch.payload.data_value[VALUE_WIDTH-1:0];
        scan_q <= '0;
        rank_q <= '0;
        pres_q <= bits_q[in_ch.payload.key_byte];
      end
      S_RANK: if (scan_q != CountW'(key_q)) begin
        rank_q <= rank_q + CountW'(bits_q[sk]);
        scan_q <= scan_q + CountW'(1);
      end else if (go_dense) begin
        // Hold the rank for a plain item; restart from the top for the dense walk.
        scan_q <= CountW'(NumSlots - 1);
        rank_q <= count_q;
      end
      S_DENSE: begin
        rank_q <= rank_q - CountW'(bits_q[sk]);
        scan_q <= scan_q - CountW'(1);
      end
      S_EXEC: begin
        rd_q <= (mode_q == MODE_GET && pres_q)
          ? DataW'(slot_v[direct_q ? key_q : rank_q[KeyW-1:0]]) : '0;
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid = (state_q == S_OUT);
  assign out_ch.payload.read_value = rd_q;
  assign out_ch.payload.was_present = pres_q;
  assign out_ch.payload.key_count = count_q;

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(NumSlots)) else $error("count overflow");
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(direct_q) |-> direct_q) else $error("left direct mode");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> $stable(rd_q)) else $error("result changed");
endmodule

// ===== verif/tb_top.sv =====
// Testbench for the sparse bitmap value store: a keyed shadow store predicts every result.
// Depends on sbvs_pkg, sbvs_if and sparse_bitmap_value_store_top.
`timescale 1ns / 100ps

module tb_top;
  import sbvs_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 600;

  // Shadow of the store kept by key; packing order inside the block is not visible outside.
  class store_scoreboard;
    bit              present[NumSlots];
    logic [DataW-1:0] value_of[NumSlots];
    int unsigned     count;
    rsp_t            expected_q[$];
    int unsigned     mismatches;
    int unsigned     checked;

    function void note_request(req_t req);
      rsp_t rsp;
      rsp.was_present = present[req.key_byte];
      rsp.read_value  = '0;
      if (req.mode == MODE_GET) begin
        if (present[req.key_byte]) rsp.read_value = value_of[req.key_byte];
      end else begin
        if (!present[req.key_byte]) count++;
        present[req.key_byte]  = 1'b1;
        value_of[req.key_byte] = req.data_value;
      end
      rsp.key_count = count[CountW-1:0];
      expected_q.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: response with none expected: %p", got);
        return;
      end
      want = expected_q.pop_front();
      if (got.read_value !== want.read_value || got.was_present !== want.was_present ||
          got.key_count !== want.key_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: value exp %h got %h, present exp %b got %b, count exp %0d got %0d",
                   want.read_value, got.read_value, want.was_present, got.was_present,
                   want.key_count, got.key_count);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  sbvs_if #(.payload_t(req_t)) in_ch ();
  sbvs_if #(.payload_t(rsp_t)) out_ch ();

  sparse_bitmap_value_store_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  store_scoreboard sb = new();
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 48;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;
  int unsigned gets = 0, puts = 0, max_count = 0;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.payload);
    if (out_ch.valid && out_ch.ready) sb.check_response(out_ch.payload);
  end

  task automatic send_request(logic mode, logic [KeyW-1:0] key, logic [DataW-1:0] data);
    req_t req;
    req.mode = mode;
    req.key_byte = key;
    req.data_value = data;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (mode == MODE_GET) gets++; else puts++;
  endtask

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'($urandom_range(NumSlots - 1));
  endfunction

  // Pick an absent key when one exists, to drive the store toward the dense switch and full.
  function automatic logic [KeyW-1:0] absent_key();
    int unsigned start = $urandom_range(NumSlots - 1);
    for (int unsigned i = 0; i < NumSlots; i++)
      if (!sb.present[(start + i) % NumSlots]) return KeyW'((start + i) % NumSlots);
    return KeyW'(start);
  endfunction

  task automatic random_phase(int unsigned n, int unsigned fill_pct);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 45) begin
        send_request(MODE_GET, rand_key(), rand_value());
      end else if ($urandom_range(99) < fill_pct) begin
        send_request(MODE_PUT, absent_key(), rand_value());
      end else begin
        send_request(MODE_PUT, rand_key(), rand_value());
      end
      if (sb.count > max_count) max_count = sb.count;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty gets, extreme keys and values, overwrite, get misses.
    send_request(MODE_GET, 8'd0, '1);
    send_request(MODE_GET, 8'd255, '0);
    send_request(MODE_PUT, 8'd255, '0);
    send_request(MODE_PUT, 8'd0, '1);
    send_request(MODE_PUT, 8'd128, 64'h8000_0000_0000_0001);
    send_request(MODE_GET, 8'd0, '0);
    send_request(MODE_GET, 8'd255, '1);
    send_request(MODE_GET, 8'd128, '0);
    send_request(MODE_PUT, 8'd0, 64'h5555_AAAA_5555_AAAA);
    send_request(MODE_GET, 8'd0, '0);
    send_request(MODE_GET, 8'd1, '0);
    send_request(MODE_PUT, 8'd1, 64'hAAAA_5555_AAAA_5555);
    send_request(MODE_GET, 8'd1, '0);
    send_request(MODE_GET, 8'd127, '0);
    send_request(MODE_PUT, 8'd127, 64'h0123_4567_89AB_CDEF);
    send_request(MODE_GET, 8'd128, '0);

    // Packed mode and the dense switch.
    random_phase(470, 30);
    send_idle_pct = 48;
    recv_idle_pct = 29;
    // Fill to full, then run with every put an overwrite.
    random_phase(450, 80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 3000;
    random_phase(460, 50);

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d gets and %0d puts, %0d responses, peak key count %0d.",
             gets, puts, sb.checked, max_count);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, left over: %0d", sb.mismatches, sb.expected_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sparse_bitmap_value_store_top.f =====
design/sbvs_pkg.sv
design/sbvs_if.sv
design/sbvs_cell.sv
design/sparse_bitmap_value_store_top.sv
verif/tb_top.sv
